### rtl/imu_ca_pkg.sv
package imu_ca_pkg;

	// Field widths fixed by the sensor and register formats
	localparam int GYRO_BITS   = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int PERIOD_BITS = 24;
	localparam int ANGLE_BITS  = 32;

	// Arctangent works in degrees with 24 fraction bits
	localparam int TAB_FRAC  = 24;
	localparam int TAB_LEN   = 24;
	localparam int TAB_IDX_W = 5;
	localparam int ZW        = 33;

	// Gyro product, predicted angle and blend accumulator widths
	localparam int PROD_W = GYRO_BITS + PERIOD_BITS;
	localparam int PW     = 42;
	localparam int SW     = 61;

	localparam logic signed [ZW-1:0] Z_DEG90  = 33'sd1509949440;
	localparam logic signed [ZW-1:0] Z_DEG180 = 33'sd3019898880;

	// round(atan(2^-i) * 180/pi * 2^24)
	localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;
	localparam logic [WEIGHT_BITS-1:0] BLEND_WEIGHT_RST  = 16'd58982;
	localparam logic [PERIOD_BITS-1:0] SAMPLE_PERIOD_RST = 24'd83886;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] roll_angle;
		logic signed [31:0] pitch_angle;
		logic signed [31:0] yaw_angle;
	} out_item_t;

	// Sequencer strobes shared by the three angle lanes
	typedef struct packed {
		logic load_g;
		logic step_g;
		logic last_g;
		logic prep;
		logic load_b;
		logic step_b;
		logic commit;
	} lane_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_PREP,
		ST_LOAD,
		ST_BLEND,
		ST_DONE
	} state_t;

endpackage

### rtl/imu_ca_cordic.sv
module imu_ca_cordic #(
	parameter int ITERS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [16:0]                 y_in,
	input  logic signed [15:0]                 x_in,
	output logic signed [imu_ca_pkg::ZW-1:0]   z
);

	localparam int CW = 44;
	localparam int IW = $clog2(ITERS + 1);

	logic signed [CW-1:0] x_q, y_q;
	logic signed [imu_ca_pkg::ZW-1:0] z_q;
	logic [IW-1:0] iter_q;
	logic hold_q;

	logic signed [17:0] xs0, ys0, xp, yp;
	logic signed [imu_ca_pkg::ZW-1:0] zp, tab;
	logic signed [CW-1:0] xsh, ysh;
	logic run;

	// Quadrant fold so the vector starts in the right half plane
	always_comb begin
		xs0 = {{2{x_in[15]}}, x_in};
		ys0 = {y_in[16], y_in};
		xp  = xs0;
		yp  = ys0;
		zp  = '0;
		if (x_in[15]) begin
			if (!y_in[16]) begin
				xp = ys0;
				yp = -xs0;
				zp = imu_ca_pkg::Z_DEG90;
			end else begin
				xp = -ys0;
				yp = xs0;
				zp = -imu_ca_pkg::Z_DEG90;
			end
		end
	end

	assign run = !hold_q && (iter_q != IW'(ITERS));
	assign xsh = x_q >>> iter_q;
	assign ysh = y_q >>> iter_q;
	assign tab = imu_ca_pkg::ZW'(imu_ca_pkg::ATAN_TAB[imu_ca_pkg::TAB_IDX_W'(iter_q)]);

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= IW'(ITERS);
			hold_q <= 1'b1;
		end else if (start) begin
			iter_q <= '0;
			hold_q <= (y_in == '0) || (x_in == '0);
		end else if (run) begin
			iter_q <= iter_q + IW'(1);
		end
	end

	// One micro-rotation per cycle while run is high
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CW'(xp) <<< imu_ca_pkg::TAB_FRAC;
			y_q <= CW'(yp) <<< imu_ca_pkg::TAB_FRAC;
			if (y_in == '0)
				z_q <= x_in[15] ? imu_ca_pkg::Z_DEG180 : '0;
			else if (x_in == '0)
				z_q <= y_in[16] ? -imu_ca_pkg::Z_DEG90 : imu_ca_pkg::Z_DEG90;
			else
				z_q <= zp;
		end else if (run) begin
			if (y_q > 0) begin
				x_q <= x_q + ysh;
				y_q <= y_q - xsh;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ysh;
				y_q <= y_q + xsh;
				z_q <= z_q - tab;
			end
		end
	end

	assign z = z_q;

endmodule

### rtl/imu_ca_lane.sv
module imu_ca_lane #(
	parameter int FRAC    = 16,
	parameter bit USE_ACC = 1'b1
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  imu_ca_pkg::lane_ctrl_t                      ctrl,
	input  logic signed [imu_ca_pkg::GYRO_BITS-1:0]     gyro,
	input  logic [imu_ca_pkg::PERIOD_BITS-1:0]          period,
	input  logic [imu_ca_pkg::WEIGHT_BITS-1:0]          weight,
	input  logic signed [imu_ca_pkg::ZW-1:0]            acc_q24,
	output logic signed [imu_ca_pkg::ANGLE_BITS-1:0]    angle
);

	localparam int PROD_W = imu_ca_pkg::PROD_W;
	localparam int PW     = imu_ca_pkg::PW;
	localparam int SW     = imu_ca_pkg::SW;
	localparam int ZW     = imu_ca_pkg::ZW;
	localparam int SH     = imu_ca_pkg::TAB_FRAC - FRAC;
	localparam logic signed [SW-1:0] HI = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] LO = -SW'(64'sd2147483648);

	logic signed [31:0] angle_q;
	logic [imu_ca_pkg::GYRO_BITS-1:0] g_sr_q;
	logic signed [PROD_W-1:0] mc_q, prod_q;
	logic signed [PW-1:0] pred_q;
	logic signed [ZW-1:0] accr_q;
	logic [imu_ca_pkg::WEIGHT_BITS-1:0] w_sr_q;
	logic signed [SW-1:0] d_q, sum_q;

	logic signed [PW-1:0] prod_ext, gterm;
	logic signed [ZW-1:0] accr;
	logic signed [SW-1:0] rnd;

	assign prod_ext = PW'(prod_q);

	// Round to the angle format, half up
	generate
		if (SH == 0) begin : g_noshift
			assign gterm = prod_ext;
			assign accr  = acc_q24;
		end else begin : g_shift
			assign gterm = (prod_ext + (PW'(1) <<< (SH - 1))) >>> SH;
			assign accr  = (acc_q24 + (ZW'(1) <<< (SH - 1))) >>> SH;
		end
	endgenerate

	assign rnd = (sum_q + (SW'(1) <<< 15)) >>> 16;

	// Bit-serial products: gyro*period then weight*(pred-acc)
	always_ff @(posedge clk) begin
		if (ctrl.load_g) begin
			g_sr_q <= gyro;
			mc_q   <= PROD_W'({1'b0, period});
			prod_q <= '0;
		end else if (ctrl.step_g) begin
			g_sr_q <= g_sr_q >> 1;
			mc_q   <= mc_q <<< 1;
			if (g_sr_q[0])
				prod_q <= ctrl.last_g ? prod_q - mc_q : prod_q + mc_q;
		end
		if (ctrl.prep) begin
			pred_q <= PW'(angle_q) + gterm;
			accr_q <= USE_ACC ? accr : '0;
		end
		if (ctrl.load_b) begin
			w_sr_q <= weight;
			d_q    <= SW'(pred_q) - SW'(accr_q);
			sum_q  <= SW'(accr_q) <<< 16;
		end else if (ctrl.step_b) begin
			w_sr_q <= w_sr_q >> 1;
			d_q    <= d_q <<< 1;
			if (w_sr_q[0])
				sum_q <= sum_q + d_q;
		end
	end

	// Stored angle, saturated on update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (ctrl.commit) begin
			if (rnd > HI)
				angle_q <= 32'sh7fffffff;
			else if (rnd < LO)
				angle_q <= 32'sh80000000;
			else
				angle_q <= rnd[31:0];
		end
	end

	assign angle = angle_q;

endmodule

### rtl/imu_complementary_attitude.sv
// Complementary-filter attitude estimator, one raw six-axis sample per beat.
// Input channel: in_valid/in_stall/in_data; a beat is taken when in_valid is
// high and in_stall low. in_stall is high while a sample is being worked on.
// Output channel: out_valid/out_stall/out_data carries roll, pitch and yaw in
// signed fixed-point degrees; the beat is held while out_stall is high.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// index 0 is the gyro blend weight, index 1 the sample period.
// Each sample passes through the run, prep, load, blend and done states;
// the next sample is taken only once it has been committed. The rate is
// set by the bit-serial multipliers and one arctangent rotation per cycle.
// A new sample may be taken while the previous result waits to be taken;
// its result is held back until the output register is free.
// Reset clears the stored angles to zero and restores the default weight
// and period.
module imu_complementary_attitude #(
	parameter int ARCTAN_ITERATIONS   = 16,
	parameter int ANGLE_FRACTION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  imu_ca_pkg::in_item_t                   in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output imu_ca_pkg::out_item_t                  out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [imu_ca_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imu_ca_pkg::PERIOD_BITS-1:0]     cfg_data
);

	localparam int RUN_LEN = (ARCTAN_ITERATIONS > 16) ? ARCTAN_ITERATIONS : 16;
	localparam int CNT_W   = $clog2(RUN_LEN + 1);

	imu_ca_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic [imu_ca_pkg::WEIGHT_BITS-1:0] weight_q;
	logic [imu_ca_pkg::PERIOD_BITS-1:0] period_q;
	imu_ca_pkg::lane_ctrl_t ctrl;
	logic take, cnt_clr;
	logic signed [imu_ca_pkg::ZW-1:0] roll_z, pitch_z;
	logic signed [16:0] roll_y, pitch_y;

	assign in_stall  = (state_q != imu_ca_pkg::ST_IDLE);
	assign take      = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= imu_ca_pkg::BLEND_WEIGHT_RST;
			period_q <= imu_ca_pkg::SAMPLE_PERIOD_RST;
		end else if (cfg_valid) begin
			if (cfg_index == imu_ca_pkg::REG_BLEND_WEIGHT)
				weight_q <= cfg_data[imu_ca_pkg::WEIGHT_BITS-1:0];
			else if (cfg_index == imu_ca_pkg::REG_SAMPLE_PERIOD)
				weight_q <= weight_q;
			if (cfg_index == imu_ca_pkg::REG_SAMPLE_PERIOD)
				period_q <= cfg_data;
		end
	end

	// Sequencer next state and lane strobes
	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		cnt_clr     = 1'b0;
		ctrl.load_g = take;
		unique case (state_q)
			imu_ca_pkg::ST_IDLE: begin
				cnt_clr = 1'b1;
				if (take)
					state_d = imu_ca_pkg::ST_RUN;
			end
			imu_ca_pkg::ST_RUN: begin
				ctrl.step_g = (cnt_q < CNT_W'(16));
				ctrl.last_g = (cnt_q == CNT_W'(15));
				if (cnt_q == CNT_W'(RUN_LEN - 1)) begin
					state_d = imu_ca_pkg::ST_PREP;
					cnt_clr = 1'b1;
				end
			end
			imu_ca_pkg::ST_PREP: begin
				ctrl.prep = 1'b1;
				state_d   = imu_ca_pkg::ST_LOAD;
			end
			imu_ca_pkg::ST_LOAD: begin
				ctrl.load_b = 1'b1;
				cnt_clr     = 1'b1;
				state_d     = imu_ca_pkg::ST_BLEND;
			end
			imu_ca_pkg::ST_BLEND: begin
				ctrl.step_b = 1'b1;
				if (cnt_q == CNT_W'(15))
					state_d = imu_ca_pkg::ST_DONE;
			end
			imu_ca_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ctrl.commit = 1'b1;
					state_d     = imu_ca_pkg::ST_IDLE;
				end
			end
			default: state_d = imu_ca_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imu_ca_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_clr ? '0 : cnt_q + CNT_W'(1);
			if (ctrl.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Accelerometer angles
	assign roll_y  = {in_data.accel_y[15], in_data.accel_y};
	assign pitch_y = -{in_data.accel_x[15], in_data.accel_x};

	imu_ca_cordic #(.ITERS(ARCTAN_ITERATIONS)) u_roll_atan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (take),
		.y_in   (roll_y),
		.x_in   (in_data.accel_z),
		.z      (roll_z)
	);

	imu_ca_cordic #(.ITERS(ARCTAN_ITERATIONS)) u_pitch_atan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (take),
		.y_in   (pitch_y),
		.x_in   (in_data.accel_z),
		.z      (pitch_z)
	);

	// Angle lanes
	imu_ca_lane #(.FRAC(ANGLE_FRACTION_BITS), .USE_ACC(1'b1)) u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.gyro    (in_data.gyro_x),
		.period  (period_q),
		.weight  (weight_q),
		.acc_q24 (roll_z),
		.angle   (out_data.roll_angle)
	);

	imu_ca_lane #(.FRAC(ANGLE_FRACTION_BITS), .USE_ACC(1'b1)) u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.gyro    (in_data.gyro_y),
		.period  (period_q),
		.weight  (weight_q),
		.acc_q24 (pitch_z),
		.angle   (out_data.pitch_angle)
	);

	imu_ca_lane #(.FRAC(ANGLE_FRACTION_BITS), .USE_ACC(1'b0)) u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.gyro    (in_data.gyro_z),
		.period  (period_q),
		.weight  (weight_q),
		.acc_q24 ('0),
		.angle   (out_data.yaw_angle)
	);

endmodule

### verif/tb_imu_complementary_attitude.sv
module tb_imu_complementary_attitude;

	localparam int ITERS     = 16;
	localparam int FRAC      = 16;
	localparam int N_RANDOM  = 1725;
	localparam int DRAIN_CYC = 80;
	localparam int WDOG_LIM  = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	imu_ca_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	imu_ca_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [imu_ca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [imu_ca_pkg::PERIOD_BITS-1:0] cfg_data = '0;

	imu_complementary_attitude #(
		.ARCTAN_ITERATIONS(ITERS),
		.ANGLE_FRACTION_BITS(FRAC)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state and registers
	logic [imu_ca_pkg::WEIGHT_BITS-1:0] weight_q;
	logic [imu_ca_pkg::PERIOD_BITS-1:0] period_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q;

	imu_ca_pkg::out_item_t angle_queue[$];
	bit fixed_queue[$];
	imu_ca_pkg::out_item_t fixed_value_queue[$];
	int n_errors = 0;
	int n_results = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_sh(longint v, int s);
		if (s == 0) begin
			return v;
		end
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// CORDIC vectoring arctangent in degrees, 24 fraction bits
	function automatic longint atan2_degrees(longint y, longint x);
		longint one, z, t, xs, ys;
		int n;
		one = 64'sd1 <<< imu_ca_pkg::TAB_FRAC;
		z = 0;
		if (y == 0) begin
			return (x < 0) ? 180 * one : 0;
		end
		if (x == 0) begin
			return (y > 0) ? 90 * one : -90 * one;
		end
		x = x * one;
		y = y * one;
		if (x < 0) begin
			if (y > 0) begin
				t = x; x = y; y = -t; z = 90 * one;
			end else begin
				t = x; x = -y; y = t; z = -90 * one;
			end
		end
		n = (ITERS > imu_ca_pkg::TAB_LEN) ? imu_ca_pkg::TAB_LEN : ITERS;
		for (int i = 0; i < n; i++) begin
			xs = floor_sh(x, i);
			ys = floor_sh(y, i);
			if (y > 0) begin
				x = x + ys; y = y - xs; z += longint'(imu_ca_pkg::ATAN_TAB[i]);
			end else begin
				x = x - ys; y = y + xs; z -= longint'(imu_ca_pkg::ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic logic signed [31:0] blend_angle(logic signed [31:0] prev,
			longint rate, longint acc24, bit with_acc);
		longint w, pred, sum;
		w = longint'(weight_q);
		pred = longint'(prev) + round_sh(rate * longint'(period_q), 24 - FRAC);
		sum = w * pred;
		if (with_acc) begin
			sum += (65536 - w) * round_sh(acc24, imu_ca_pkg::TAB_FRAC - FRAC);
		end
		return clip32(round_sh(sum, 16));
	endfunction

	function automatic imu_ca_pkg::out_item_t predict_attitude(imu_ca_pkg::in_item_t s);
		imu_ca_pkg::out_item_t r;
		longint ax, ay, az;
		ax = longint'(s.accel_x);
		ay = longint'(s.accel_y);
		az = longint'(s.accel_z);
		roll_q  = blend_angle(roll_q, longint'(s.gyro_x), atan2_degrees(ay, az), 1'b1);
		pitch_q = blend_angle(pitch_q, longint'(s.gyro_y), atan2_degrees(-ax, az), 1'b1);
		yaw_q   = blend_angle(yaw_q, longint'(s.gyro_z), 0, 1'b0);
		r.roll_angle = roll_q;
		r.pitch_angle = pitch_q;
		r.yaw_angle = yaw_q;
		return r;
	endfunction

	// output side: random stall bursts, compare each beat
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 16) - 1;
				out_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				burst = 0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		imu_ca_pkg::out_item_t want;
		bit use_fixed;
		imu_ca_pkg::out_item_t fixed_val;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (angle_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				n_errors++;
			end else begin
				want = angle_queue.pop_front();
				use_fixed = fixed_queue.pop_front();
				fixed_val = fixed_value_queue.pop_front();
				if (use_fixed) begin
					want = fixed_val;
				end
				if (out_data.roll_angle !== want.roll_angle) begin
					$display("%0t: roll expected %0d actual %0d", $time,
						want.roll_angle, out_data.roll_angle);
					n_errors++;
				end
				if (out_data.pitch_angle !== want.pitch_angle) begin
					$display("%0t: pitch expected %0d actual %0d", $time,
						want.pitch_angle, out_data.pitch_angle);
					n_errors++;
				end
				if (out_data.yaw_angle !== want.yaw_angle) begin
					$display("%0t: yaw expected %0d actual %0d", $time,
						want.yaw_angle, out_data.yaw_angle);
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WDOG_LIM) begin
			$display("simulation failed");
			$finish;
		end
	end

	// one register write, then valid is taken down before the task returns
	task automatic write_reg(logic [imu_ca_pkg::CFG_IDX_W-1:0] idx,
			logic [imu_ca_pkg::PERIOD_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == imu_ca_pkg::REG_BLEND_WEIGHT) begin
			weight_q = val[imu_ca_pkg::WEIGHT_BITS-1:0];
		end else if (idx == imu_ca_pkg::REG_SAMPLE_PERIOD) begin
			period_q = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (angle_queue.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	// one input beat, optional pre-typed expectation; valid stays up after
	// the beat until a gap or the drain task takes it down
	task automatic send_sample(imu_ca_pkg::in_item_t s, bit fixed,
			imu_ca_pkg::out_item_t fixed_val);
		int gap;
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		angle_queue.push_back(predict_attitude(s));
		fixed_queue.push_back(fixed);
		fixed_value_queue.push_back(fixed_val);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	typedef struct {
		imu_ca_pkg::in_item_t sample;
		bit fixed;
		imu_ca_pkg::out_item_t result;
	} stim_row_t;

	stim_row_t directed_rows[$];

	function automatic imu_ca_pkg::in_item_t mk(int ax, int ay, int az, int gx, int gy,
			int gz);
		imu_ca_pkg::in_item_t s;
		s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
		s.gyro_x = 16'(gx); s.gyro_y = 16'(gy); s.gyro_z = 16'(gz);
		return s;
	endfunction

	initial begin
		stim_row_t row;
		imu_ca_pkg::in_item_t s;
		imu_ca_pkg::out_item_t none;
		logic [15:0] weights[5] = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd58982};
		logic [23:0] periods[5] = '{24'd0, 24'hffffff, 24'd83886, 24'd1, 24'd4194304};
		none = '0;
		weight_q = imu_ca_pkg::BLEND_WEIGHT_RST;
		period_q = imu_ca_pkg::SAMPLE_PERIOD_RST;
		roll_q = 0;
		pitch_q = 0;
		yaw_q = 0;

		// all zero after reset: both arctangents at the origin, state stays 0
		directed_rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1'b1, '0});
		directed_rows.push_back('{mk(0, 0, 1000, 0, 0, 0), 1'b0, none});
		directed_rows.push_back('{mk(0, 0, -1000, 0, 0, 0), 1'b0, none});
		directed_rows.push_back('{mk(0, 1000, 0, 0, 0, 0), 1'b0, none});
		directed_rows.push_back('{mk(1000, -1000, 0, 0, 0, 0), 1'b0, none});
		directed_rows.push_back('{mk(-32768, 32767, -32768, 0, 0, 0), 1'b0, none});
		directed_rows.push_back('{mk(32767, -32768, 32767, 32767, 32767, 32767), 1'b0, none});
		directed_rows.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768),
			1'b0, none});
		directed_rows.push_back('{mk(5, 7, -3, 100, -100, 50), 1'b0, none});
		directed_rows.push_back('{mk(-3, -7, 5, -1, 1, -1), 1'b0, none});
		directed_rows.push_back('{mk(1, 1, 1, 1, 1, 1), 1'b0, none});
		directed_rows.push_back('{mk(-1, 0, -1, 0, 0, 0), 1'b0, none});

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k]) begin
			send_sample(directed_rows[k].sample, directed_rows[k].fixed,
				directed_rows[k].result);
		end
		wait_results_drained();

		// saturation: full gyro weight, longest period, max rate
		write_reg(imu_ca_pkg::REG_BLEND_WEIGHT, 24'(16'd65535));
		write_reg(imu_ca_pkg::REG_SAMPLE_PERIOD, 24'hffffff);
		write_reg(2'd2, 24'd12345);
		write_reg(2'd3, 24'd777);
		repeat (12) send_sample(mk(0, 0, 0, 32767, -32768, 32767), 1'b0, none);
		repeat (12) send_sample(mk(0, 0, 0, -32768, 32767, -32768), 1'b0, none);
		// sender holds off until all is drained
		wait_results_drained();

		// random part over several settings
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(imu_ca_pkg::REG_BLEND_WEIGHT, 24'(weights[ph]));
			write_reg(imu_ca_pkg::REG_SAMPLE_PERIOD, periods[ph]);
			if (ph == 4) begin
				no_idle = 1'b1;
			end
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				s.accel_x = rand_field(); s.accel_y = rand_field();
				s.accel_z = rand_field(); s.gyro_x = rand_field();
				s.gyro_y = rand_field(); s.gyro_z = rand_field();
				send_sample(s, 1'b0, none);
			end
			wait_results_drained();
		end

		$display("covered %0d results across weight and period extremes,", n_results);
		$display("axis and origin arctangent cases and angle saturation");
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/imu_ca_pkg.sv
rtl/imu_ca_cordic.sv
rtl/imu_ca_lane.sv
rtl/imu_complementary_attitude.sv
verif/tb_imu_complementary_attitude.sv
